// File: hdl/pulse_beat_detector_assert.svh
// ---------------------------------------------------------------------------
// pulse_beat_detector_assert.svh
// Assertion macros used by the pulse beat detector checker.
// ---------------------------------------------------------------------------
`ifndef PULSE_BEAT_DETECTOR_ASSERT_SVH
`define PULSE_BEAT_DETECTOR_ASSERT_SVH

// Clocked property that is switched off while reset is held.
`define PBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold in and out of reset.
`define PBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pbd_pkg.sv
// ---------------------------------------------------------------------------
// pbd_pkg
// Shared constants, register codes and types of the pulse beat detector.
// ---------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

    localparam int unsigned WINDOW_DEPTH = 512;
    localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned TOT_W        = SAMPLE_W + IDX_W;
    localparam int unsigned STEP_W       = $clog2(TOT_W + 1);
    localparam int unsigned CENTER_W     = 18;
    localparam int unsigned ADDR_W       = 5;
    localparam int unsigned OUT_DATA_W   = 40;

    localparam logic [SAMPLE_W-1:0] GAIN_RST  = 16'd6554;
    localparam logic [SAMPLE_W-1:0] UPPER_RST = 16'd29788;
    localparam logic [SAMPLE_W-1:0] LOWER_RST = 16'd19859;
    localparam logic [SAMPLE_W-1:0] NUM_RST   = 16'd4800;
    localparam logic [SAMPLE_W-1:0] LIMIT_RST = 16'd200;

    localparam logic signed [CENTER_W-1:0] CENTER_OFFSET = 18'sd32768;

    typedef enum logic [2:0] {
        REG_GAIN  = 3'd0,
        REG_UPPER = 3'd1,
        REG_LOWER = 3'd2,
        REG_NUM   = 3'd3,
        REG_LIMIT = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_UPDATE,
        ST_DIV_MEAN,
        ST_DIV_RATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

// File: hdl/pbd_div.sv
// ---------------------------------------------------------------------------
// pbd_div
// Radix-2 restoring divider, one quotient bit per clock cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pbd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbd_pkg::t_div_ctl             i_ctl,
    input  logic [pbd_pkg::TOT_W-1:0]     i_dividend,
    input  logic [pbd_pkg::CNT_W-1:0]     i_divisor,
    output pbd_pkg::t_div_sts             o_sts,
    output logic [pbd_pkg::TOT_W-1:0]     o_quotient
);

    logic                        r_busy;
    logic                        r_done;
    logic [pbd_pkg::STEP_W-1:0]  r_cnt;
    logic [pbd_pkg::TOT_W-1:0]   r_quo;
    logic [pbd_pkg::CNT_W-1:0]   r_rem;
    logic [pbd_pkg::CNT_W-1:0]   r_den;

    logic [pbd_pkg::CNT_W:0]     w_shift;
    logic [pbd_pkg::CNT_W:0]     w_diff;
    logic                        w_ge;

    // The dividend enters MSB first; a run shorter than the word expects
    // its dividend aligned to the top bits.
    assign w_shift = {r_rem, r_quo[pbd_pkg::TOT_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Done pulses for one cycle after the last quotient bit.
            r_done <= r_busy && !i_ctl.start && (r_cnt == pbd_pkg::STEP_W'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - pbd_pkg::STEP_W'(1);
                if (r_cnt == pbd_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pbd_pkg::TOT_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[pbd_pkg::CNT_W-1:0] : w_shift[pbd_pkg::CNT_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: hdl/pulse_beat_detector.sv
// ---------------------------------------------------------------------------
// pulse_beat_detector
// Pulse-sensor front end: smoothing, baseline removal and beat-rate output.
// ---------------------------------------------------------------------------
// Usage:
// One converter sample enters on the slave stream (s_axis); the block takes
// it only when o_s_axis_tready is high, and then drops tready until the item
// is finished. Each sample yields exactly one result item on the master
// stream (m_axis): the centered value and the beat rate in tdata, the beat
// and rate-valid flags in tuser.
// A single shared radix-2 divider, which gives one quotient bit a cycle,
// computes first the window mean and then, on a beat, the rate. The
// input reopens in the cycle after the result is registered.
// Reset restores the register defaults, empties the window and re-arms the
// detector; no clearing pass is needed since an old window entry is only
// used once the store has been filled. A result waits in the output
// register while the receiver stalls; the next sample is processed
// meanwhile and held back only at its very end until the output register
// is free. The user must write registers over the APB-style port only
// while no sample is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module pulse_beat_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream. tdata: raw_sample[15:0].
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [pbd_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,
    // Output stream. tdata: centered_value[17:0], rate_bpm[33:18], zero pad.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [pbd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // tuser: beat[0], rate_valid[1].
    output logic [1:0]                        o_m_axis_tuser,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbd_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int unsigned SW = pbd_pkg::SAMPLE_W;
    localparam int unsigned IW = pbd_pkg::IDX_W;
    localparam int unsigned CW = pbd_pkg::CNT_W;
    localparam int unsigned TW = pbd_pkg::TOT_W;
    localparam int unsigned QW = pbd_pkg::CENTER_W;

    // Configuration registers.
    logic [SW-1:0] r_gain;
    logic [SW-1:0] r_upper;
    logic [SW-1:0] r_lower;
    logic [SW-1:0] r_num;
    logic [SW-1:0] r_limit;

    // Sequencer and detector state.
    pbd_pkg::t_state r_state;
    pbd_pkg::t_state n_state;
    logic [IW-1:0]   r_wr_idx;
    logic            r_full;
    logic [TW-1:0]   r_total;
    logic [SW-1:0]   r_mean;
    logic [SW-1:0]   r_prev;
    logic            r_have_prev;
    logic            r_armed;
    logic            r_have_first;
    logic [IW-1:0]   r_last_beat;
    logic            r_beat;
    logic            r_m_valid;

    // Working registers of the item in flight.
    logic [SW-1:0]          r_raw;
    logic [SW-1:0]          r_old;
    logic [32:0]            r_acc;
    logic [SW-1:0]          r_smooth;
    logic signed [QW-1:0]   r_centered;
    logic [CW-1:0]          r_diff;
    logic [SW-1:0]          r_bpm;
    logic                   r_rate_ok;

    // Output payload.
    logic signed [QW-1:0]   r_out_centered;
    logic                   r_out_beat;
    logic [SW-1:0]          r_out_bpm;
    logic                   r_out_rate_ok;

    // Window store; its contents are undefined until written.
    logic [SW-1:0] r_window [pbd_pkg::WINDOW_DEPTH];

    // Combinational signals.
    logic                   w_accept;
    logic                   w_load_out;
    logic                   w_cfg_wr;
    pbd_pkg::t_reg_idx      w_reg_idx;
    logic [16:0]            w_mul_a;
    logic [SW-1:0]          w_mul_b;
    logic [32:0]            w_prod;
    logic [32:0]            w_sum;
    logic [SW-1:0]          n_smooth;
    logic signed [QW-1:0]   n_centered;
    logic [TW-1:0]          n_total;
    logic [CW-1:0]          w_idx_ext;
    logic [CW-1:0]          w_last_ext;
    logic [CW-1:0]          n_diff;
    logic                   w_above;
    logic                   w_below;
    pbd_pkg::t_div_ctl      w_div_ctl;
    pbd_pkg::t_div_sts      w_div_sts;
    logic [TW-1:0]          w_dividend;
    logic [CW-1:0]          w_divisor;
    logic [TW-1:0]          w_quotient;
    logic [SW-1:0]          w_quo16;

    // ------------------------------------------------------------------
    // Register port. Every register holds 16 bits; upper data bits drop.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = pbd_pkg::t_reg_idx'(paddr[pbd_pkg::ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            pbd_pkg::REG_GAIN:  prdata = {16'd0, r_gain};
            pbd_pkg::REG_UPPER: prdata = {16'd0, r_upper};
            pbd_pkg::REG_LOWER: prdata = {16'd0, r_lower};
            pbd_pkg::REG_NUM:   prdata = {16'd0, r_num};
            pbd_pkg::REG_LIMIT: prdata = {16'd0, r_limit};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier. The first pass forms alpha * raw, the second adds
    // (1 - alpha) * previous; alpha of zero makes the second weight 65536,
    // hence the 17-bit operand.
    // ------------------------------------------------------------------
    assign w_mul_a = (r_state == pbd_pkg::ST_MUL_A) ? {1'b0, r_gain}
                                                    : 17'h10000 - {1'b0, r_gain};
    assign w_mul_b = (r_state == pbd_pkg::ST_MUL_A) ? r_raw : r_prev;
    assign w_prod  = 33'(w_mul_a) * 33'(w_mul_b);
    assign w_sum   = r_acc + w_prod;

    // The first sample after reset passes through unsmoothed.
    assign n_smooth = r_have_prev ? w_sum[31:16] : r_raw;

    // Centered value against the mean left by the previous sample.
    assign n_centered = r_have_prev
        ? $signed({2'b00, r_smooth}) + pbd_pkg::CENTER_OFFSET - $signed({2'b00, r_mean})
        : $signed({2'b00, r_raw});

    // Running total: once the window is full the oldest entry leaves it.
    assign n_total = r_full ? r_total - TW'(r_old) + TW'(r_smooth)
                            : r_total + TW'(r_smooth);

    // Distance to the previous beat around the circular index; a distance
    // of zero means a whole window.
    assign w_idx_ext  = CW'(r_wr_idx);
    assign w_last_ext = CW'(r_last_beat);
    always_comb begin
        if (w_idx_ext >= w_last_ext) begin
            n_diff = w_idx_ext - w_last_ext;
        end else begin
            n_diff = w_idx_ext + CW'(pbd_pkg::WINDOW_DEPTH) - w_last_ext;
        end
        if (n_diff == '0) begin
            n_diff = CW'(pbd_pkg::WINDOW_DEPTH);
        end
    end

    // Threshold compares are signed, so a negative level never beats.
    assign w_above = (n_centered > $signed({2'b00, r_upper}));
    assign w_below = (n_centered < $signed({2'b00, r_lower}));

    assign w_quo16 = w_quotient[SW-1:0];

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbd_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = pbd_pkg::ST_MUL_A;
                end
            end
            pbd_pkg::ST_MUL_A:  n_state = pbd_pkg::ST_MUL_B;
            pbd_pkg::ST_MUL_B:  n_state = pbd_pkg::ST_UPDATE;
            pbd_pkg::ST_UPDATE: n_state = pbd_pkg::ST_DIV_MEAN;
            pbd_pkg::ST_DIV_MEAN: begin
                if (w_div_sts.done) begin
                    n_state = r_beat ? pbd_pkg::ST_DIV_RATE : pbd_pkg::ST_FINISH;
                end
            end
            pbd_pkg::ST_DIV_RATE: begin
                if (w_div_sts.done) begin
                    n_state = pbd_pkg::ST_FINISH;
                end
            end
            pbd_pkg::ST_FINISH: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_state = pbd_pkg::ST_IDLE;
                end
            end
            default: n_state = pbd_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. The divider first takes the new total over the
    // fill count (or the depth once full); on a beat it then takes the
    // numerator, aligned to its top bits, over the beat distance.
    // ------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready   = 1'b0;
        w_load_out        = 1'b0;
        w_div_ctl.start   = 1'b0;
        w_div_ctl.steps   = pbd_pkg::STEP_W'(TW);
        w_dividend        = n_total;
        w_divisor         = r_full ? CW'(pbd_pkg::WINDOW_DEPTH) : w_idx_ext + CW'(1);
        unique case (r_state)
            pbd_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            pbd_pkg::ST_UPDATE: begin
                w_div_ctl.start = 1'b1;
            end
            pbd_pkg::ST_DIV_MEAN: begin
                w_div_ctl.start = w_div_sts.done && r_beat;
                w_div_ctl.steps = pbd_pkg::STEP_W'(SW);
                w_dividend      = {r_num, {(TW - SW){1'b0}}};
                w_divisor       = r_diff;
            end
            pbd_pkg::ST_FINISH: begin
                w_load_out = !r_m_valid || i_m_axis_tready;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    pbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts),
        .o_quotient (w_quotient)
    );

    // ------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= pbd_pkg::GAIN_RST;
            r_upper      <= pbd_pkg::UPPER_RST;
            r_lower      <= pbd_pkg::LOWER_RST;
            r_num        <= pbd_pkg::NUM_RST;
            r_limit      <= pbd_pkg::LIMIT_RST;
            r_state      <= pbd_pkg::ST_IDLE;
            r_wr_idx     <= '0;
            r_full       <= 1'b0;
            r_total      <= '0;
            r_mean       <= '0;
            r_prev       <= '0;
            r_have_prev  <= 1'b0;
            r_armed      <= 1'b1;
            r_have_first <= 1'b0;
            r_last_beat  <= '0;
            r_beat       <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    pbd_pkg::REG_GAIN:  r_gain  <= pwdata[SW-1:0];
                    pbd_pkg::REG_UPPER: r_upper <= pwdata[SW-1:0];
                    pbd_pkg::REG_LOWER: r_lower <= pwdata[SW-1:0];
                    pbd_pkg::REG_NUM:   r_num   <= pwdata[SW-1:0];
                    pbd_pkg::REG_LIMIT: r_limit <= pwdata[SW-1:0];
                    default: begin
                        r_gain <= r_gain;
                    end
                endcase
            end

            if (r_state == pbd_pkg::ST_UPDATE) begin
                r_total     <= n_total;
                r_prev      <= r_smooth;
                r_have_prev <= 1'b1;
                // Only a beat after the first one reports a rate.
                r_beat      <= w_above && r_armed && r_have_first;
                if (w_above && r_armed) begin
                    r_armed      <= 1'b0;
                    r_have_first <= 1'b1;
                    r_last_beat  <= r_wr_idx;
                end else if (w_below) begin
                    r_armed <= 1'b1;
                end
                if (r_wr_idx == IW'(pbd_pkg::WINDOW_DEPTH - 1)) begin
                    r_wr_idx <= '0;
                    r_full   <= 1'b1;
                end else begin
                    r_wr_idx <= r_wr_idx + IW'(1);
                end
            end

            if (r_state == pbd_pkg::ST_DIV_MEAN && w_div_sts.done) begin
                r_mean <= w_quo16;
            end

            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw <= i_s_axis_tdata;
        end
        if (r_state == pbd_pkg::ST_MUL_A) begin
            r_acc <= w_prod;
        end
        if (r_state == pbd_pkg::ST_MUL_B) begin
            r_smooth <= n_smooth;
        end
        if (r_state == pbd_pkg::ST_UPDATE) begin
            r_centered <= n_centered;
            r_diff     <= n_diff;
            r_bpm      <= '0;
            r_rate_ok  <= 1'b0;
        end
        if (r_state == pbd_pkg::ST_DIV_RATE && w_div_sts.done) begin
            r_bpm     <= w_quo16;
            r_rate_ok <= (w_quo16 < r_limit);
        end
        if (w_load_out) begin
            r_out_centered <= r_centered;
            r_out_beat     <= r_beat;
            r_out_bpm      <= r_bpm;
            r_out_rate_ok  <= r_rate_ok;
        end
    end

    // Window store: the oldest entry is read as the sample is taken and the
    // new smoothed value is written in its place during the update.
    always_ff @(posedge i_clk) begin
        if (r_state == pbd_pkg::ST_UPDATE) begin
            r_window[r_wr_idx] <= r_smooth;
        end
        if (w_accept) begin
            r_old <= r_window[r_wr_idx];
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(pbd_pkg::OUT_DATA_W - QW - SW){1'b0}},
                              r_out_bpm, r_out_centered};
    assign o_m_axis_tuser  = {r_out_rate_ok, r_out_beat};

endmodule

`default_nettype wire

// File: hdl/pbd_checker.sv
// ---------------------------------------------------------------------------
// pbd_checker
// Port-level checks of the pulse beat detector, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pulse_beat_detector_assert.svh"

module pbd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [pbd_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [pbd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input logic [1:0]                        o_m_axis_tuser,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [pbd_pkg::ADDR_W-1:0]        paddr,
    input logic [31:0]                       pwdata,
    input logic [31:0]                       prdata,
    input logic                              pready
);

    logic w_in_take;
    logic w_out_stall;
    logic w_no_beat;
    logic w_bpm_zero;

    assign w_in_take   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_no_beat   = o_m_axis_tvalid && !o_m_axis_tuser[0];
    assign w_bpm_zero  = (o_m_axis_tdata[33:18] == 16'd0);

    // The register port never inserts wait states.
    `PBD_ASSERT_ALWAYS(a_pready_high, i_clk, pready, "pready dropped")

    // A sample is worked on alone: the input closes right after acceptance.
    `PBD_ASSERT(a_one_item, i_clk, i_rst_n, w_in_take |=> !o_s_axis_tready, "input reopened early")

    // A stalled result keeps its payload.
    `PBD_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // A valid rate only comes with a beat.
    `PBD_ASSERT(a_rate_beat, i_clk, i_rst_n, o_m_axis_tvalid |-> !o_m_axis_tuser[1] || o_m_axis_tuser[0], "rate flagged without beat")

    // Without a beat the rate field reads zero.
    `PBD_ASSERT(a_bpm_zero, i_clk, i_rst_n, w_no_beat |-> w_bpm_zero, "rate nonzero without beat")

endmodule

bind pulse_beat_detector pbd_checker u_pbd_checker (.*);

`default_nettype wire
